// ----- design/csvfs_pkg.sv -----
// Shared types and constants of the CSV field splitter.
`default_nettype none

package csvfs_pkg;

  // Width of the max_field_len configuration register.
  localparam int CfgW = 10;
  // Largest limit the configuration register can express.
  localparam int CfgMax = (1 << CfgW) - 1;

  // Defaults of the top-level parameters.
  localparam int FieldLenMaxDef   = 1023;
  localparam int FieldIndexMaxDef = 255;

  // Entries of the result queue; it must hold two results of one request
  // on top of two that are waiting.
  localparam int QueueDepth = 4;

  // Characters with a meaning to the parser.
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Result kinds.
  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       cut;
    logic [7:0] fnum;
    logic       last;
  } result_t;

  // Results of one request, handed from the parser to the queue.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// ----- design/csvfs_parser.sv -----
// Input register, line parser state and per-request result logic.
`default_nettype none

module csvfs_parser #(
  parameter int FIELD_LEN_MAX   = csvfs_pkg::FieldLenMaxDef,
  parameter int FIELD_INDEX_MAX = csvfs_pkg::FieldIndexMaxDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [7:0]             in_byte_i,
  input  wire logic                   end_of_string_i,
  input  wire logic                   cfg_valid_i,
  input  wire logic [csvfs_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic                   room_i,
  output csvfs_pkg::push_t            push_o
);

  localparam int LenCapI = (FIELD_LEN_MAX < csvfs_pkg::CfgMax) ?
                           FIELD_LEN_MAX : csvfs_pkg::CfgMax;
  localparam int CntW = $clog2(LenCapI + 1);
  localparam logic [csvfs_pkg::CfgW-1:0] LenCap = csvfs_pkg::CfgW'(LenCapI);
  localparam int IdxCapI = (FIELD_INDEX_MAX < 255) ? FIELD_INDEX_MAX : 255;
  localparam logic [7:0] IdxCap = 8'(IdxCapI);

  localparam logic [2:0] ModeStart  = 3'd0;
  localparam logic [2:0] ModePlain  = 3'd1;
  localparam logic [2:0] ModeQuoted = 3'd2;
  localparam logic [2:0] ModeQseen  = 3'd3;
  localparam logic [2:0] ModeDone   = 3'd4;

  logic                        in_vld_q;
  logic [7:0]                  in_byte_q;
  logic                        in_eos_q;
  logic [csvfs_pkg::CfgW-1:0]  cfg_q;
  logic [2:0]                  mode_q, mode_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [7:0]                  fidx_q, fidx_d;

  logic [csvfs_pkg::CfgW-1:0]  limit;
  logic                        full;
  logic                        fire;
  logic                        eos;
  logic                        is_eol;
  logic [7:0]                  fidx_inc, fidx_inc2;
  logic [1:0]                  n;
  csvfs_pkg::result_t          r0, r1;

  function automatic csvfs_pkg::result_t mk_end(logic cut, logic [7:0] fnum);
    csvfs_pkg::result_t r;
    r.kind = csvfs_pkg::KindEnd;
    r.data = 8'h00;
    r.cut  = cut;
    r.fnum = fnum;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic csvfs_pkg::result_t mk_byte(logic [7:0] b, logic [7:0] fnum);
    csvfs_pkg::result_t r;
    r.kind = csvfs_pkg::KindByte;
    r.data = b;
    r.cut  = 1'b0;
    r.fnum = fnum;
    r.last = 1'b0;
    return r;
  endfunction

  // The input register is held while a request waits for queue room.
  assign in_stall_o = in_vld_q && !room_i;
  assign fire       = in_vld_q && room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
      in_eos_q  <= end_of_string_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= csvfs_pkg::CfgW'(csvfs_pkg::CfgMax);
      mode_q <= ModeStart;
      cnt_q  <= '0;
      fidx_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (fire) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
        fidx_q <= fidx_d;
      end
    end
  end

  always_comb begin
    limit = (cfg_q == '0) ? csvfs_pkg::CfgW'(1) : cfg_q;
    if (limit > LenCap) begin
      limit = LenCap;
    end
  end

  assign full      = csvfs_pkg::CfgW'(cnt_q) >= limit;
  assign eos       = in_eos_q || (in_byte_q == 8'h00);
  assign is_eol    = (in_byte_q == csvfs_pkg::ChCr) || (in_byte_q == csvfs_pkg::ChLf);
  assign fidx_inc  = (fidx_q < IdxCap) ? fidx_q + 8'd1 : fidx_q;
  assign fidx_inc2 = (fidx_inc < IdxCap) ? fidx_inc + 8'd1 : fidx_inc;

  always_comb begin
    n      = 2'd0;
    r0     = mk_byte(in_byte_q, fidx_q);
    r1     = mk_byte(in_byte_q, fidx_inc);
    mode_d = mode_q;
    cnt_d  = cnt_q;
    fidx_d = fidx_q;
    if (eos) begin
      if (mode_q <= ModeQseen) begin
        n  = 2'd1;
        r0 = mk_end(1'b0, fidx_q);
      end
      mode_d = ModeStart;
      cnt_d  = '0;
      fidx_d = '0;
    end else begin
      unique case (mode_q)
        ModeStart: begin
          if (in_byte_q == csvfs_pkg::ChQuote) begin
            mode_d = ModeQuoted;
            cnt_d  = '0;
          end else if (in_byte_q == csvfs_pkg::ChComma || is_eol) begin
            n      = 2'd1;
            r0     = mk_end(1'b0, fidx_q);
            fidx_d = fidx_inc;
            cnt_d  = '0;
            mode_d = is_eol ? ModeDone : ModeStart;
          end else begin
            n      = 2'd1;
            cnt_d  = CntW'(1);
            mode_d = ModePlain;
          end
        end
        ModePlain: begin
          if (in_byte_q == csvfs_pkg::ChComma || is_eol) begin
            n      = 2'd1;
            r0     = mk_end(1'b0, fidx_q);
            fidx_d = fidx_inc;
            cnt_d  = '0;
            mode_d = is_eol ? ModeDone : ModeStart;
          end else if (full) begin
            // The byte that did not fit opens the next field.
            r0     = mk_end(1'b1, fidx_q);
            fidx_d = fidx_inc;
            if (in_byte_q == csvfs_pkg::ChQuote) begin
              n      = 2'd1;
              cnt_d  = '0;
              mode_d = ModeQuoted;
            end else begin
              n      = 2'd2;
              cnt_d  = CntW'(1);
              mode_d = ModePlain;
            end
          end else begin
            n     = 2'd1;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        ModeQuoted: begin
          if (full) begin
            r0     = mk_end(1'b1, fidx_q);
            fidx_d = fidx_inc;
            cnt_d  = '0;
            if (in_byte_q == csvfs_pkg::ChComma) begin
              n      = 2'd1;
              mode_d = ModeStart;
            end else if (in_byte_q == csvfs_pkg::ChQuote) begin
              n      = 2'd1;
              mode_d = ModeQuoted;
            end else if (is_eol) begin
              // The line break closes an empty field of its own.
              n      = 2'd2;
              r1     = mk_end(1'b0, fidx_inc);
              fidx_d = fidx_inc2;
              mode_d = ModeDone;
            end else begin
              n      = 2'd2;
              cnt_d  = CntW'(1);
              mode_d = ModePlain;
            end
          end else if (in_byte_q == csvfs_pkg::ChQuote) begin
            mode_d = ModeQseen;
          end else begin
            n     = 2'd1;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        ModeQseen: begin
          if (in_byte_q == csvfs_pkg::ChQuote) begin
            n      = 2'd1;
            r0     = mk_byte(csvfs_pkg::ChQuote, fidx_q);
            cnt_d  = cnt_q + CntW'(1);
            mode_d = ModeQuoted;
          end else if (in_byte_q == csvfs_pkg::ChComma || is_eol) begin
            n      = 2'd1;
            r0     = mk_end(1'b0, fidx_q);
            fidx_d = fidx_inc;
            cnt_d  = '0;
            mode_d = is_eol ? ModeDone : ModeStart;
          end else begin
            n      = 2'd2;
            r0     = mk_end(1'b0, fidx_q);
            fidx_d = fidx_inc;
            cnt_d  = CntW'(1);
            mode_d = ModePlain;
          end
        end
        default: begin
          mode_d = ModeDone;
        end
      endcase
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign push_o.n  = fire ? n : 2'd0;
  assign push_o.r0 = r0;
  assign push_o.r1 = r1;

`ifndef NO_ASSERTIONS
  a_two_results_start_with_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n == 2'd2 |-> push_o.r0.kind == csvfs_pkg::KindEnd)
    else $error("second result without a leading end mark");

  a_eos_resets_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && eos |=> mode_q == ModeStart && fidx_q == 8'd0 && cnt_q == '0)
    else $error("end of string did not restart the line");

  a_done_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !eos && mode_q == ModeDone |-> push_o.n == 2'd0)
    else $error("result produced after the line ended");
`endif

endmodule

`default_nettype wire

// ----- design/csvfs_out_queue.sv -----
// Small result queue that takes up to two results a cycle and gives one unless the receiver stalls.
`default_nettype none

module csvfs_out_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire csvfs_pkg::push_t  push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output csvfs_pkg::result_t     head_o
);

  localparam int Depth = csvfs_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  csvfs_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               pop;
  logic [PtrW-1:0]    wr_ptr_nxt;

  assign out_valid_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = count_q <= CntW'(Depth - 2);
  assign wr_ptr_nxt  = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i.n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.r1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> count_q <= CntW'(Depth - 2))
    else $error("push into a queue without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n == 2'd0 && !pop |=> $stable(count_q))
    else $error("queue count moved without a push or pop");
`endif

endmodule

`default_nettype wire

// ----- design/csv_field_splitter.sv -----
// Top level of the CSV field splitter: parser and result queue.
//
// Usage: one CSV line enters on the input channel, one byte per request
// (in_byte_i, end_of_string_i). A byte of zero or end_of_string_i high
// ends the line. For each field the block sends its content bytes and then
// an end-of-field mark with the field number; a request gives zero, one or
// two results, and last_of_run_o marks the final one of a request.
// A result passes the input register and is then written into the output
// queue by the parser, from where it leaves.
// Throughput: one request per cycle while the receiver keeps up. A request
// with two results leaves one extra entry in the four-entry queue, so a run
// of such requests slows the input to the output rate of one result a cycle.
// The configuration channel writes max_field_len; it is always ready, and the
// user must write it only while the block is idle; the block does not enforce it.
// Reset clears the parser to the start of a line, empties the queue and
// sets the limit to its largest value. When the receiver stalls, the head
// result holds; once the queue is nearly full in_stall_o rises.
`default_nettype none

module csv_field_splitter #(
  parameter int FIELD_LEN_MAX   = csvfs_pkg::FieldLenMaxDef,
  parameter int FIELD_INDEX_MAX = csvfs_pkg::FieldIndexMaxDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 in_byte_i,
  input  wire logic                       end_of_string_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            out_kind_o,
  output logic [7:0]                      out_byte_o,
  output logic                            cut_off_o,
  output logic [7:0]                      field_number_o,
  output logic                            last_of_run_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [csvfs_pkg::CfgW-1:0] cfg_data_i
);

  csvfs_pkg::push_t   push;
  csvfs_pkg::result_t head;
  logic               room;

  // The limit register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  csvfs_parser #(
    .FIELD_LEN_MAX  (FIELD_LEN_MAX),
    .FIELD_INDEX_MAX(FIELD_INDEX_MAX)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_string_i(end_of_string_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .room_i         (room),
    .push_o         (push)
  );

  csvfs_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign out_kind_o     = head.kind;
  assign out_byte_o     = head.data;
  assign cut_off_o      = head.cut;
  assign field_number_o = head.fnum;
  assign last_of_run_o  = head.last;

endmodule

`default_nettype wire

// ----- tb/csv_split_checker.sv -----
`timescale 1ns / 100ps
// Checker of the CSV field splitter: predicts the results of each request and compares them.
module csv_split_checker #(
  parameter int FIELD_LEN_MAX   = csvfs_pkg::FieldLenMaxDef,
  parameter int FIELD_INDEX_MAX = csvfs_pkg::FieldIndexMaxDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [7:0]                 in_byte_i,
  input  logic                       end_of_string_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       out_kind_i,
  input  logic [7:0]                 out_byte_i,
  input  logic                       cut_off_i,
  input  logic [7:0]                 field_number_i,
  input  logic                       last_of_run_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [csvfs_pkg::CfgW-1:0] cfg_data_i,
  output int                         mismatch_count_o,
  output int                         open_count_o
);
  import csvfs_pkg::*;

  typedef enum logic [2:0] {
    ModeStart,
    ModePlain,
    ModeQuoted,
    ModeQuoteSeen,
    ModeDone
  } split_mode_e;

  localparam int IndexCap = (FIELD_INDEX_MAX < 255) ? FIELD_INDEX_MAX : 255;

  split_mode_e     mode;
  int              field_len;
  int              field_idx;
  logic [CfgW-1:0] len_limit;
  result_t         expected_results[$];
  result_t         new_results[2];
  int              new_count;

  function automatic void emit_result(logic kind, logic [7:0] data, logic cut);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.cut  = cut;
    r.fnum = field_idx[7:0];
    r.last = 1'b0;
    new_results[new_count] = r;
    new_count++;
  endfunction

  function automatic void close_field(logic cut);
    emit_result(KindEnd, 8'h00, cut);
    if (field_idx < IndexCap) field_idx++;
    field_len = 0;
  endfunction

  // First byte of a field decides whether it is quoted, empty or plain.
  function automatic void open_field(logic [7:0] b);
    field_len = 0;
    if (b == ChQuote) begin
      mode = ModeQuoted;
    end else if (b == ChComma) begin
      close_field(1'b0);
      mode = ModeStart;
    end else if (b == ChCr || b == ChLf) begin
      close_field(1'b0);
      mode = ModeDone;
    end else begin
      emit_result(KindByte, b, 1'b0);
      field_len = 1;
      mode = ModePlain;
    end
  endfunction

  // Works out the results of one request and queues them.
  function automatic void split_byte(logic [7:0] b, logic eos);
    int   lim;
    logic full;
    lim = (len_limit == '0) ? 1 : int'(len_limit);
    if (lim > FIELD_LEN_MAX) lim = FIELD_LEN_MAX;
    full = (field_len >= lim);
    new_count = 0;
    if (eos || b == 8'h00) begin
      if (mode != ModeDone) close_field(1'b0);
      mode = ModeStart;
      field_len = 0;
      field_idx = 0;
    end else begin
      case (mode)
        ModeStart: begin
          open_field(b);
        end
        ModePlain: begin
          if (b == ChComma) begin
            close_field(1'b0);
            mode = ModeStart;
          end else if (b == ChCr || b == ChLf) begin
            close_field(1'b0);
            mode = ModeDone;
          end else if (full) begin
            close_field(1'b1);
            open_field(b);
          end else begin
            emit_result(KindByte, b, 1'b0);
            field_len++;
          end
        end
        ModeQuoted: begin
          if (full) begin
            close_field(1'b1);
            if (b == ChComma) mode = ModeStart;
            else open_field(b);
          end else if (b == ChQuote) begin
            mode = ModeQuoteSeen;
          end else begin
            emit_result(KindByte, b, 1'b0);
            field_len++;
          end
        end
        ModeQuoteSeen: begin
          if (b == ChQuote) begin
            emit_result(KindByte, ChQuote, 1'b0);
            field_len++;
            mode = ModeQuoted;
          end else if (b == ChComma) begin
            close_field(1'b0);
            mode = ModeStart;
          end else if (b == ChCr || b == ChLf) begin
            close_field(1'b0);
            mode = ModeDone;
          end else begin
            close_field(1'b0);
            open_field(b);
          end
        end
        default: begin
          mode = ModeDone;
        end
      endcase
    end
    if (new_count > 0) new_results[new_count-1].last = 1'b1;
    for (int i = 0; i < new_count; i++) expected_results.push_back(new_results[i]);
  endfunction

  // Results leave before new requests are predicted, so a result can never be
  // matched against an expectation of the same clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      mode = ModeStart;
      field_len = 0;
      field_idx = 0;
      len_limit = CfgW'(CfgMax);
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {out_kind_i, out_byte_i, cut_off_i, field_number_i, last_of_run_i};
        if (expected_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: unexpected result kind %0d byte %02h cut %0d field %0d last %0d",
                     $time, got.kind, got.data, got.cut, got.fnum, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.cut !== want.cut ||
              got.fnum !== want.fnum || got.last !== want.last) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%0t: result mismatch: expected kind %0d byte %02h cut %0d field %0d last %0d, got kind %0d byte %02h cut %0d field %0d last %0d",
                       $time, want.kind, want.data, want.cut, want.fnum, want.last,
                       got.kind, got.data, got.cut, got.fnum, got.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) split_byte(in_byte_i, end_of_string_i);
      if (cfg_valid_i && cfg_ready_i) len_limit = cfg_data_i;
    end
    open_count_o = expected_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the CSV field splitter testbench: clock, reset, stimulus and verdict.
module testbench;
  import csvfs_pkg::*;

  // Cycles after which a hung run is ended as failed.
  localparam int CycleLimit = 1000000;

  logic            clk           = 1'b0;
  logic            rst_n         = 1'b0;
  logic            in_valid      = 1'b0;
  logic [7:0]      in_byte       = 8'h00;
  logic            end_of_string = 1'b0;
  logic            out_stall     = 1'b0;
  logic            cfg_valid     = 1'b0;
  logic [CfgW-1:0] cfg_data      = '0;
  logic            in_stall;
  logic            out_valid;
  logic            out_kind;
  logic [7:0]      out_byte;
  logic            cut_off;
  logic [7:0]      field_number;
  logic            last_of_run;
  logic            cfg_ready;

  int mismatches;
  int open_results;

  // Stimulus bookkeeping. cur_limit is the limit the block acts on, used to
  // size fields so that they often run into it.
  int sent      = 0;
  int cur_limit = CfgMax;
  bit idle_on   = 1'b1;
  int idle_odds = 4;

  csv_field_splitter i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .end_of_string_i(end_of_string),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_kind_o     (out_kind),
    .out_byte_o     (out_byte),
    .cut_off_o      (cut_off),
    .field_number_o (field_number),
    .last_of_run_o  (last_of_run),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  csv_split_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_byte_i       (in_byte),
    .end_of_string_i (end_of_string),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_kind_i      (out_kind),
    .out_byte_i      (out_byte),
    .cut_off_i       (cut_off),
    .field_number_i  (field_number),
    .last_of_run_i   (last_of_run),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatches),
    .open_count_o    (open_results)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The receiver stalls in random bursts, with quiet stretches between
  // them. Once idle_on drops, stall stays low.
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("** csv_field_splitter: FAILED **");
    $finish;
  end

  // Sends one request. It is entered at a falling edge and returns at the
  // falling edge after the request was taken, with valid still high, so the
  // next request can follow without a gap. Callers that pause lower valid.
  task automatic send_request(logic [7:0] b, logic eos);
    if (idle_on && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // A line ends either by the end_of_string flag, with a byte that must be
  // ignored, or by a zero byte.
  task automatic send_eos();
    if ($urandom_range(0, 1) == 1) send_request(8'($urandom_range(0, 255)), 1'b1);
    else send_request(8'h00, 1'b0);
  endtask

  // The limit is written only with the block idle: valid is lowered, all
  // expected results must have left, and a further wait covers requests that
  // give no result but may still be in the pipeline.
  task automatic write_limit(int v);
    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[CfgW-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_limit = (v == 0) ? 1 : v;
  endtask

  // Random field content. Inside quotes everything but the quote is content,
  // CR, LF and comma included. A plain field stops at comma, CR and LF, and
  // a quote is content there unless it opens the field.
  function automatic logic [7:0] pick_content(bit quoted, bit first);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (quoted ? (b == ChQuote)
                  : (b == ChComma || b == ChCr || b == ChLf || (first && b == ChQuote)));
    return b;
  endfunction

  // A well-formed line with random content: plain and quoted fields with
  // doubled quotes, lengths around the limit when it is small, and every
  // kind of line ending. Now and then the comma after a closing quote is
  // left out, so the next field starts right after the quote.
  task automatic send_line();
    int nf;
    int len;
    bit quoted;
    nf = $urandom_range(1, 6);
    idle_odds = 3 * $urandom_range(0, 3);
    for (int f = 0; f < nf; f++) begin
      quoted = ($urandom_range(0, 2) == 0);
      if (cur_limit <= 64) len = $urandom_range(0, cur_limit + 2);
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 20);
      else len = $urandom_range(0, 6);
      if (quoted) begin
        send_request(ChQuote, 1'b0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_request(ChQuote, 1'b0);
            send_request(ChQuote, 1'b0);
          end else begin
            send_request(pick_content(1'b1, 1'b0), 1'b0);
          end
        end
        send_request(ChQuote, 1'b0);
      end else begin
        for (int i = 0; i < len; i++) send_request(pick_content(1'b0, i == 0), 1'b0);
      end
      if (f < nf - 1 && !(quoted && $urandom_range(0, 9) == 0)) send_request(ChComma, 1'b0);
    end
    case ($urandom_range(0, 4))
      1: send_request(ChCr, 1'b0);
      2: send_request(ChLf, 1'b0);
      3: begin
        send_request(ChCr, 1'b0);
        send_request(ChLf, 1'b0);
      end
      4: send_request(ChComma, 1'b0);
      default: ;
    endcase
    // Bytes after the end of the line must be ignored; some lines carry a few.
    repeat ($urandom_range(0, 3)) send_request(8'($urandom_range(1, 255)), 1'b0);
    send_eos();
  endtask

  // Noise: random bytes, heavy on the characters that steer the parser, so
  // quotes open and close at odd places and lines break off mid-field.
  task automatic send_noise_line();
    int n;
    n = $urandom_range(1, 12);
    idle_odds = 3 * $urandom_range(0, 3);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: send_request(ChQuote, 1'b0);
        1: send_request(ChComma, 1'b0);
        2: send_request(($urandom_range(0, 1) == 1) ? ChCr : ChLf, 1'b0);
        default: send_request(8'($urandom_range(1, 255)), 1'b0);
      endcase
    end
    send_eos();
  endtask

  initial begin
    string line_a;
    string line_b;
    int    phase_limits[8];
    int    goal;

    // Plain field, comma, quoted field with a doubled quote, comma, empty
    // field, CR with trailing junk.
    line_a = "a,\"x\"\"y\",,\015z";
    // A byte right after a closing quote starts the next field; LF ends it.
    line_b = "\"q\"b\012";

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with the limit at its reset value.
    idle_odds = 0;
    for (int i = 0; i < line_a.len(); i++) send_request(line_a[i], 1'b0);
    // The line is already done after CR, so this end of string gives nothing.
    send_request(8'hFF, 1'b1);
    for (int i = 0; i < line_b.len(); i++) send_request(line_b[i], 1'b0);
    send_request(8'h00, 1'b0);
    // Top-bit bytes in a plain field, closed by end of string.
    send_request(8'hFF, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h5A, 1'b1);
    // LF at field start closes an empty field; end of string at line start
    // closes an empty one as well.
    send_request(ChLf, 1'b0);
    send_request(8'h00, 1'b1);
    send_request(8'hC3, 1'b1);

    // Random phases, each with its own limit: zero acts as one, the small
    // ones cut fields off all the time, the largest almost never.
    phase_limits = '{0, 1, 2, 3, $urandom_range(4, 9), $urandom_range(10, 64),
                     $urandom_range(65, 1022), CfgMax};
    for (int p = 0; p < 8; p++) begin
      write_limit(phase_limits[p]);
      goal = sent + 90;
      while (sent < goal) begin
        if ($urandom_range(0, 6) == 0) send_noise_line();
        else send_line();
      end
    end

    // Enough empty fields in one line to saturate the field number, then a
    // one-byte field that is numbered at the cap.
    idle_odds = 6;
    repeat (260) send_request(ChComma, 1'b0);
    send_request(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    send_request(ChLf, 1'b0);
    send_eos();

    // Last part at full rate on both sides.
    write_limit(2);
    idle_on = 1'b0;
    goal = sent + 90;
    while (sent < goal) begin
      if ($urandom_range(0, 6) == 0) send_noise_line();
      else send_line();
    end

    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) $display("** csv_field_splitter: PASSED **");
    else $display("** csv_field_splitter: FAILED **");
    $finish;
  end

endmodule
